[rtl/delimited_frame_receiver_assert.svh]
// Assertion macros used by the frame receiver parser.
`ifndef DELIMITED_FRAME_RECEIVER_ASSERT_SVH
`define DELIMITED_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset.
`define DFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define DFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DFR_ASSERT(lbl, clk, rst_n, prop, msg)
`define DFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/dfr_pkg.sv]
// Package: constants, types and register codes of the frame receiver.
`timescale 1ns / 1ps

package dfr_pkg;

    localparam int HEADER_BYTES = 6;
    localparam int MAX_FRAME    = 512;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int OFF_W     = 9;
    localparam int POS_W     = $clog2(MAX_FRAME + 1);
    localparam int HDR_IDX_W = $clog2(HEADER_BYTES);
    localparam int CFG_IDX_W = 2;

    // header byte positions
    localparam int HDR_TYPE   = 1;
    localparam int HDR_ID     = 2;
    localparam int HDR_STATUS = 3;
    localparam int HDR_LEN_HI = 4;
    localparam int HDR_LEN_LO = 5;

    localparam logic [BYTE_W-1:0] CMD_ID_ONE = 8'h01;

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd254;
    localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'd253;
    localparam logic [BYTE_W-1:0] NOTIF_TYPE_RST = 8'd7;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_FRAME   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BYTE = 2'd0,
        CFG_END_BYTE   = 2'd1,
        CFG_NOTIF_TYPE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [BYTE_W-1:0] notification_type;
    } t_cfg;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [OFF_W-1:0]  payload_offset;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] command_id;
        logic [BYTE_W-1:0] header_status;
        logic [LEN_W-1:0]  payload_size;
        logic              is_notification;
        logic              answers_command;
    } t_result;

endpackage

[rtl/dfr_rx_if.sv]
// Interface: received byte channel.
`timescale 1ns / 1ps

interface dfr_rx_if import dfr_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

[rtl/dfr_res_if.sv]
// Interface: result channel (payload bytes and frame completions).
`timescale 1ns / 1ps

interface dfr_res_if import dfr_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [OFF_W-1:0]  payload_offset;
    logic [BYTE_W-1:0] frame_type;
    logic [BYTE_W-1:0] command_id;
    logic [BYTE_W-1:0] header_status;
    logic [LEN_W-1:0]  payload_size;
    logic              is_notification;
    logic              answers_command;

    modport source (
        output valid, output kind, output payload_byte, output payload_offset,
        output frame_type, output command_id, output header_status,
        output payload_size, output is_notification, output answers_command,
        input  ready
    );
    modport sink (
        input  valid, input kind, input payload_byte, input payload_offset,
        input  frame_type, input command_id, input header_status,
        input  payload_size, input is_notification, input answers_command,
        output ready
    );

endinterface

[rtl/dfr_cfg.sv]
// Configuration registers: start, end and notification type bytes.
`timescale 1ns / 1ps

module dfr_cfg import dfr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_START_BYTE: n_cfg.start_byte        = i_cfg_wdata;
                CFG_END_BYTE:   n_cfg.end_byte          = i_cfg_wdata;
                CFG_NOTIF_TYPE: n_cfg.notification_type = i_cfg_wdata;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte        <= START_BYTE_RST;
            r_cfg.end_byte          <= END_BYTE_RST;
            r_cfg.notification_type <= NOTIF_TYPE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/dfr_parser.sv]
// Frame parser: position, length and header state, and per-byte result decode.
`timescale 1ns / 1ps

`include "delimited_frame_receiver_assert.svh"

module dfr_parser import dfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output logic              o_res_valid,
    output t_result           o_res
);

    logic [POS_W-1:0]  r_pos;
    logic [LEN_W-1:0]  r_len;
    logic [BYTE_W-1:0] r_hdr [HEADER_BYTES];

    logic [POS_W-1:0]  n_pos;
    logic [LEN_W-1:0]  n_len;

    logic              w_start;
    logic [POS_W-1:0]  w_pos;
    logic              w_sat;
    logic              w_in_hdr;
    logic              w_hdr_wr;
    logic [POS_W-1:0]  w_offset;
    logic              w_payload;
    logic              w_complete;
    logic              w_notif;

    // a start byte restarts the frame before anything else is decided
    assign w_start  = (i_byte == i_cfg.start_byte);
    assign w_pos    = w_start ? '0 : r_pos;
    assign w_sat    = (w_pos == POS_W'(MAX_FRAME));
    assign w_in_hdr = (w_pos < POS_W'(HEADER_BYTES));
    assign w_hdr_wr = !w_sat && w_in_hdr;
    assign w_offset = w_pos - POS_W'(HEADER_BYTES);

    assign w_payload  = !w_sat && !w_in_hdr && (LEN_W'(w_offset) < r_len);
    assign w_complete = !w_sat && (i_byte == i_cfg.end_byte) &&
                        ((LEN_W + 1)'(w_pos) ==
                         (LEN_W + 1)'(r_len) + (LEN_W + 1)'(HEADER_BYTES));

    assign w_notif = (r_hdr[HDR_TYPE] == i_cfg.notification_type);

    always_comb begin
        n_pos = r_pos;
        n_len = r_len;
        if (w_complete) begin
            n_pos = '0;
            n_len = '0;
        end else begin
            n_pos = w_sat ? w_pos : w_pos + POS_W'(1);
            if (w_hdr_wr && (w_pos == POS_W'(HDR_LEN_LO))) begin
                n_len = {r_hdr[HDR_LEN_HI], i_byte};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_len <= '0;
            for (int i = 0; i < HEADER_BYTES; i++) begin
                r_hdr[i] <= '0;
            end
        end else if (i_step) begin
            r_pos <= n_pos;
            r_len <= n_len;
            for (int i = 0; i < HEADER_BYTES; i++) begin
                if (w_hdr_wr && (w_pos[HDR_IDX_W-1:0] == HDR_IDX_W'(i))) begin
                    r_hdr[i] <= i_byte;
                end
            end
        end
    end

    always_comb begin
        o_res = '0;
        if (w_complete) begin
            o_res.kind            = KIND_FRAME;
            o_res.frame_type      = r_hdr[HDR_TYPE];
            o_res.command_id      = r_hdr[HDR_ID];
            o_res.header_status   = r_hdr[HDR_STATUS];
            o_res.payload_size    = r_len;
            o_res.is_notification = w_notif;
            o_res.answers_command = !w_notif ||
                                    ((r_hdr[HDR_ID] == CMD_ID_ONE) && (r_len != '0));
        end else if (w_payload) begin
            o_res.kind           = KIND_PAYLOAD;
            o_res.payload_byte   = i_byte;
            o_res.payload_offset = OFF_W'(w_offset);
        end
    end

    assign o_res_valid = w_complete || w_payload;

    `DFR_ASSERT(a_pos_range, i_clk, i_rst_n, r_pos <= POS_W'(MAX_FRAME), "byte position beyond frame limit")
    `DFR_ASSERT(a_kind_excl, i_clk, i_rst_n, !(w_payload && w_complete), "payload byte and completion together")
    `DFR_ASSERT_NEXT(a_frame_clears, i_clk, i_rst_n, i_step && w_complete, (r_pos == '0) && (r_len == '0), "position or length not cleared after completion")
    `DFR_ASSERT_NEXT(a_sat_holds, i_clk, i_rst_n, i_step && w_sat, r_pos == POS_W'(MAX_FRAME), "saturated position moved without a start byte")

endmodule

[rtl/delimited_frame_receiver.sv]
// Top level of the delimited frame receiver: configuration registers, input register, parser, result register.
`timescale 1ns / 1ps

// Parses start/end delimited frames from a received byte stream. One byte is
// taken per cycle unless the input stalls; a byte passes an input register,
// is decoded by the parser against the current frame state, and any result
// lands in the output register, which presents it to the sink. Throughput is
// one byte per cycle while the result channel is ready; the input stalls only
// when both registers are full and the output is held. Results: a payload
// byte with its offset, or a frame summary when an end byte arrives exactly
// after header plus payload length. Configuration (start byte, end byte,
// notification type) is written at indices 0..2.

module delimited_frame_receiver import dfr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dfr_rx_if.sink               i_rx,
    dfr_res_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_wdata
);

    t_cfg              w_cfg;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out_res;

    logic              n_in_valid;
    logic              n_out_valid;
    logic              w_proc;
    logic              w_res_valid;
    t_result           w_res;

    dfr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    dfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_proc),
        .i_byte      (r_in_byte),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // the held byte moves on once the result register is free or draining
    assign w_proc     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || w_proc;

    always_comb begin
        n_in_valid  = i_rx.ready ? i_rx.valid : r_in_valid;
        n_out_valid = w_proc ? w_res_valid : (r_out_valid && !o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (w_proc && w_res_valid) begin
            r_out_res <= w_res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.kind            = r_out_res.kind;
    assign o_res.payload_byte    = r_out_res.payload_byte;
    assign o_res.payload_offset  = r_out_res.payload_offset;
    assign o_res.frame_type      = r_out_res.frame_type;
    assign o_res.command_id      = r_out_res.command_id;
    assign o_res.header_status   = r_out_res.header_status;
    assign o_res.payload_size    = r_out_res.payload_size;
    assign o_res.is_notification = r_out_res.is_notification;
    assign o_res.answers_command = r_out_res.answers_command;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the delimited frame receiver: random framed byte traffic, inline parser model.
`timescale 1ns / 1ps

module tb_top;
    import dfr_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dfr_rx_if  rx_ch ();
    dfr_res_if res_ch ();

    logic              cfg_we;
    t_cfg_idx          cfg_idx;
    logic [BYTE_W-1:0] cfg_wdata;

    delimited_frame_receiver dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // bytes waiting to go out on the line, and summaries/payload bytes predicted
    logic [BYTE_W-1:0] line_bytes_q[$];
    t_result           frame_events_q[$];
    logic [BYTE_W-1:0] frame_buf[$];

    int  err_count = 0;
    logic rx_took = 1'b0;

    // parser model state
    int                frame_pos = 0;
    logic [LEN_W-1:0]  frame_len = '0;
    logic [BYTE_W-1:0] hdr_seen [HEADER_BYTES];
    t_cfg              cfg_now;
    // register values as the stimulus side sees them
    t_cfg              cfg_stim;

    logic [BYTE_W-1:0] opening_bytes [24] = '{
        8'hFE, 8'h07, 8'h01, 8'h00, 8'h00, 8'h01, 8'hAA, 8'hFD,
        8'hFE, 8'h07, 8'h02, 8'h55, 8'h00, 8'h00, 8'hFD,
        8'hFE, 8'h00, 8'hFF, 8'h80, 8'h00, 8'h02, 8'hFD, 8'hFF, 8'hFD
    };

    function automatic bit parse_rx_byte(input logic [BYTE_W-1:0] b, output t_result r);
        bit hit;
        bit notif;
        hit = 1'b0;
        r   = '0;
        if (b == cfg_now.start_byte)
            frame_pos = 0;
        if (frame_pos >= MAX_FRAME)
            return 1'b0;
        if (frame_pos < HEADER_BYTES) begin
            hdr_seen[frame_pos] = b;
            if (frame_pos == HDR_LEN_LO)
                frame_len = {hdr_seen[HDR_LEN_HI], hdr_seen[HDR_LEN_LO]};
        end else if (frame_pos - HEADER_BYTES < int'(frame_len)) begin
            r.kind           = KIND_PAYLOAD;
            r.payload_byte   = b;
            r.payload_offset = OFF_W'(frame_pos - HEADER_BYTES);
            hit = 1'b1;
        end
        if (b == cfg_now.end_byte && frame_pos == HEADER_BYTES + int'(frame_len)) begin
            notif             = (hdr_seen[HDR_TYPE] == cfg_now.notification_type);
            r                 = '0;
            r.kind            = KIND_FRAME;
            r.frame_type      = hdr_seen[HDR_TYPE];
            r.command_id      = hdr_seen[HDR_ID];
            r.header_status   = hdr_seen[HDR_STATUS];
            r.payload_size    = frame_len;
            r.is_notification = notif;
            r.answers_command = !notif || (hdr_seen[HDR_ID] == CMD_ID_ONE && frame_len != 0);
            frame_pos = 0;
            frame_len = '0;
            return 1'b1;
        end
        frame_pos++;
        if (frame_pos > MAX_FRAME)
            frame_pos = MAX_FRAME;
        return hit;
    endfunction

    // sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid <= 1'b0;
        end else if (rx_ch.valid && !rx_took) begin
            // transaction still pending, hold it
        end else if (gap_left > 0) begin
            gap_left--;
            rx_ch.valid <= 1'b0;
        end else if (line_bytes_q.size() > 0) begin
            rx_ch.valid   <= 1'b1;
            rx_ch.rx_byte <= line_bytes_q[0];
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 40);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end else begin
            rx_ch.valid <= 1'b0;
        end
    end

    // receiver: stall behaviour switches among four randomly picked modes
    int cyc        = 0;
    int stall_mode = 0;
    int hold_left  = 0;

    always @(negedge i_clk) begin
        cyc++;
        if (cyc % 256 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= 1'($urandom_range(0, 1));
            2: res_ch.ready <= (cyc % 4 == 0);
            default: begin
                if (hold_left > 0) begin
                    hold_left--;
                    res_ch.ready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    hold_left = $urandom_range(5, 20);
                    res_ch.ready <= 1'b0;
                end else begin
                    res_ch.ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n) begin
            rx_took <= rx_ch.valid && rx_ch.ready;
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_START_BYTE: cfg_now.start_byte        = cfg_wdata;
                    CFG_END_BYTE:   cfg_now.end_byte          = cfg_wdata;
                    CFG_NOTIF_TYPE: cfg_now.notification_type = cfg_wdata;
                    default: ;
                endcase
            end
            if (rx_ch.valid && rx_ch.ready) begin
                void'(line_bytes_q.pop_front());
                if (parse_rx_byte(rx_ch.rx_byte, want))
                    frame_events_q.push_back(want);
            end
            if (res_ch.valid && res_ch.ready) begin
                got.kind            = res_ch.kind;
                got.payload_byte    = res_ch.payload_byte;
                got.payload_offset  = res_ch.payload_offset;
                got.frame_type      = res_ch.frame_type;
                got.command_id      = res_ch.command_id;
                got.header_status   = res_ch.header_status;
                got.payload_size    = res_ch.payload_size;
                got.is_notification = res_ch.is_notification;
                got.answers_command = res_ch.answers_command;
                if (frame_events_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: unexpected result kind %0d byte %h off %0d",
                                 $realtime, got.kind, got.payload_byte, got.payload_offset);
                end else begin
                    want = frame_events_q.pop_front();
                    if (got !== want) begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"%0t: result mismatch (exp/got) kind %0d/%0d byte %h/%h",
                                      " off %0d/%0d type %h/%h id %h/%h status %h/%h",
                                      " size %0d/%0d notif %0d/%0d answers %0d/%0d"},
                                     $realtime, want.kind, got.kind,
                                     want.payload_byte, got.payload_byte,
                                     want.payload_offset, got.payload_offset,
                                     want.frame_type, got.frame_type,
                                     want.command_id, got.command_id,
                                     want.header_status, got.header_status,
                                     want.payload_size, got.payload_size,
                                     want.is_notification, got.is_notification,
                                     want.answers_command, got.answers_command);
                    end
                end
            end
        end
    end

    function automatic logic [BYTE_W-1:0] byte_not_start();
        logic [BYTE_W-1:0] v;
        do
            v = BYTE_W'($urandom_range(0, 255));
        while (v == cfg_stim.start_byte);
        return v;
    endfunction

    // payload data leans on the end byte now and then
    function automatic logic [BYTE_W-1:0] payload_fill();
        if ($urandom_range(0, 9) == 0 && cfg_stim.end_byte != cfg_stim.start_byte)
            return cfg_stim.end_byte;
        return byte_not_start();
    endfunction

    task automatic build_frame(input int plen, input bit as_notif);
        frame_buf.delete();
        frame_buf.push_back(cfg_stim.start_byte);
        frame_buf.push_back(as_notif ? cfg_stim.notification_type : byte_not_start());
        frame_buf.push_back(($urandom_range(0, 2) == 0) ? CMD_ID_ONE : byte_not_start());
        frame_buf.push_back(byte_not_start());
        frame_buf.push_back(BYTE_W'(plen >> 8));
        frame_buf.push_back(BYTE_W'(plen));
        for (int i = 0; i < plen; i++)
            frame_buf.push_back(payload_fill());
        frame_buf.push_back(cfg_stim.end_byte);
    endtask

    task automatic send_frame_buf();
        foreach (frame_buf[i])
            line_bytes_q.push_back(frame_buf[i]);
    endtask

    task automatic run_random(input int target);
        int sent;
        int pick;
        int plen;
        int cut;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(0, 99);
            plen = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
            build_frame(plen, $urandom_range(0, 2) == 0);
            if (pick < 62) begin
                // well formed
            end else if (pick < 72) begin
                // cut short; the next start byte restarts the frame
                cut = $urandom_range(1, frame_buf.size() - 1);
                while (frame_buf.size() > cut)
                    void'(frame_buf.pop_back());
            end else if (pick < 80) begin
                frame_buf.insert($urandom_range(1, frame_buf.size() - 1), cfg_stim.end_byte);
            end else if (pick < 88) begin
                // junk between the payload and the end byte
                repeat ($urandom_range(1, 4))
                    frame_buf.insert(frame_buf.size() - 1, byte_not_start());
            end else begin
                frame_buf.delete();
                repeat ($urandom_range(1, 10)) begin
                    case ($urandom_range(0, 5))
                        0: frame_buf.push_back(cfg_stim.start_byte);
                        1: frame_buf.push_back(cfg_stim.end_byte);
                        default: frame_buf.push_back(BYTE_W'($urandom_range(0, 255)));
                    endcase
                end
            end
            send_frame_buf();
            sent += frame_buf.size();
        end
    endtask

    task automatic drain();
        while (line_bytes_q.size() > 0 || frame_events_q.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [BYTE_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_START_BYTE: cfg_stim.start_byte        = val;
            CFG_END_BYTE:   cfg_stim.end_byte          = val;
            CFG_NOTIF_TYPE: cfg_stim.notification_type = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [BYTE_W-1:0] sb, input logic [BYTE_W-1:0] eb,
                            input logic [BYTE_W-1:0] nt);
        write_reg(CFG_START_BYTE, sb);
        write_reg(CFG_END_BYTE, eb);
        write_reg(CFG_NOTIF_TYPE, nt);
    endtask

    initial begin
        foreach (hdr_seen[i])
            hdr_seen[i] = '0;
        cfg_now.start_byte        = START_BYTE_RST;
        cfg_now.end_byte          = END_BYTE_RST;
        cfg_now.notification_type = NOTIF_TYPE_RST;
        cfg_stim      = cfg_now;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_START_BYTE;
        cfg_wdata     = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready  = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: notification frames, zero length, end byte inside payload
        foreach (opening_bytes[i])
            line_bytes_q.push_back(opening_bytes[i]);
        run_random(100);
        // end byte lands on the frame limit and is ignored
        build_frame(MAX_FRAME - HEADER_BYTES, 1'b0);
        send_frame_buf();
        run_random(20);
        drain();

        // start byte zero: every zero header byte restarts the frame
        set_regs(8'h00, 8'hFF, 8'hFF);
        run_random(80);
        drain();

        set_regs(8'hFF, 8'h00, 8'h00);
        run_random(100);
        drain();

        // start and end share a value
        set_regs(8'h7E, 8'h7E, BYTE_W'($urandom_range(0, 255)));
        run_random(80);
        drain();

        set_regs(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                 BYTE_W'($urandom_range(0, 255)));
        run_random(120);
        drain();

        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/dfr_pkg.sv
rtl/dfr_rx_if.sv
rtl/dfr_res_if.sv
rtl/dfr_cfg.sv
rtl/dfr_parser.sv
rtl/delimited_frame_receiver.sv
tb/sv/tb_top.sv
